// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the text line filter.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/core/tlnvf_pkg.sv -----
// Package for the text line numbering and visualize filter.
// Character codes, register indexes and defaults; no dependencies.
`default_nettype none

package tlnvf_pkg;

    localparam int DEFAULT_NUMBER_DIGITS = 6;
    localparam int BODY_MAX              = 4;
    localparam int CFG_INDEX_W           = 3;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_NUMBER_ALL      = 3'd0;
    localparam t_cfg_index CFG_NUMBER_NONBLANK = 3'd1;
    localparam t_cfg_index CFG_SQUEEZE_BLANK   = 3'd2;
    localparam t_cfg_index CFG_SHOW_ENDS       = 3'd3;
    localparam t_cfg_index CFG_SHOW_TABS       = 3'd4;
    localparam t_cfg_index CFG_SHOW_NONPRINT   = 3'd5;

    typedef logic [7:0] t_byte;

    localparam t_byte CH_NL     = 8'h0A;
    localparam t_byte CH_TAB    = 8'h09;
    localparam t_byte CH_SPACE  = 8'h20;
    localparam t_byte CH_ZERO   = 8'h30;
    localparam t_byte CH_DOLLAR = 8'h24;
    localparam t_byte CH_CARET  = 8'h5E;
    localparam t_byte CH_I      = 8'h49;
    localparam t_byte CH_M      = 8'h4D;
    localparam t_byte CH_DASH   = 8'h2D;
    localparam t_byte CH_QMARK  = 8'h3F;
    localparam t_byte CH_DEL    = 8'h7F;
    localparam t_byte CH_CTRL_TOP   = 8'h20;
    localparam t_byte CH_CTRL_SHIFT = 8'h40;

    typedef struct packed {
        logic number_all;
        logic number_nonblank;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprint;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/core/text_line_number_and_visualize_filter_unit.sv -----
// Top level of the text line numbering and visualize filter.
// Depends on tlnvf_pkg and assert_macros.svh.
//
// Each request byte is formatted in the cycle it is accepted into a run of
// up to NUMBER_DIGITS + 5 bytes (line number and tab, then the byte itself,
// possibly as '$', ^X, ^? or an M- pair), held in a shift buffer that sends
// one byte per cycle while i_out_stall is low. The next request is taken in
// the cycle the last byte of the current run leaves, so one-byte runs flow at
// one request per cycle when the output is not stalled. Squeezed empty lines
// give no output. The output buffer draining one byte per cycle, unless
// stalled, sets the rate. The line counter is BCD and holds at all nines.
`default_nettype none
`include "assert_macros.svh"

module text_line_number_and_visualize_filter_unit #(
    parameter int NUMBER_DIGITS = tlnvf_pkg::DEFAULT_NUMBER_DIGITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tlnvf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic                          i_cfg_data,
    // input bytes
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [7:0]                    i_in_byte,
    input  wire logic                          i_file_start,
    // output bytes
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [7:0]                         o_out_byte,
    output logic                               o_run_last
);
    import tlnvf_pkg::*;

    localparam int RUN_MAX = NUMBER_DIGITS + 1 + BODY_MAX;
    localparam int CNT_W   = $clog2(RUN_MAX + 1);
    localparam int LINE_W  = 4 * NUMBER_DIGITS;

    t_cfg              r_cfg;
    logic              r_after_nl;
    logic [1:0]        r_blank;
    logic [LINE_W-1:0] r_line;
    t_byte             r_run [RUN_MAX];
    logic [CNT_W-1:0]  r_cnt;

    logic              n_after_nl;
    logic [1:0]        n_blank;
    logic [LINE_W-1:0] n_line;
    t_byte             n_run [RUN_MAX];
    logic [CNT_W-1:0]  n_len;
    logic              n_load;

    logic              in_take;
    logic              out_take;
    logic              at_start;
    logic              is_nl;
    logic              numbered;
    logic              drop;
    t_byte             body [BODY_MAX];
    logic [2:0]        body_len;
    t_byte             low_b [2];
    logic [1:0]        low_len;
    t_byte             low;
    logic [NUMBER_DIGITS:0] hi_zero;
    logic [NUMBER_DIGITS:0] nines_below;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_byte  = r_run[0];
    assign o_run_last  = (r_cnt == CNT_W'(1));
    assign out_take    = o_out_valid && !i_out_stall;
    // take a new request once the buffer is empty or its last byte leaves
    assign o_in_stall  = o_out_valid && !(o_run_last && !i_out_stall);
    assign in_take     = i_in_valid && !o_in_stall;

    // line and blank-run bookkeeping
    always_comb begin
        at_start   = r_after_nl || i_file_start;
        is_nl      = (i_in_byte == CH_NL);
        n_after_nl = is_nl;
        if (at_start && is_nl) begin
            n_blank = (r_blank == 2'd2) ? 2'd2 : r_blank + 2'd1;
        end else begin
            n_blank = 2'd0;
        end
        drop     = r_cfg.squeeze_blank && (n_blank == 2'd2);
        numbered = at_start && !(is_nl && r_cfg.number_nonblank)
                   && (r_cfg.number_all || r_cfg.number_nonblank);
    end

    // BCD count-up, holding at all nines
    always_comb begin
        nines_below[0] = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            nines_below[i+1] = nines_below[i] && (r_line[4*i +: 4] == 4'd9);
        end
        n_line = r_line;
        if (!nines_below[NUMBER_DIGITS]) begin
            for (int i = 0; i < NUMBER_DIGITS; i++) begin
                if (nines_below[i]) begin
                    n_line[4*i +: 4] = (r_line[4*i +: 4] == 4'd9) ? 4'd0
                                                                 : r_line[4*i +: 4] + 4'd1;
                end
            end
        end
    end

    // body of the run: the byte itself in its displayed form
    always_comb begin
        low = {1'b0, i_in_byte[6:0]};
        if (low < CH_CTRL_TOP) begin
            low_b[0] = CH_CARET;
            low_b[1] = low + CH_CTRL_SHIFT;
            low_len  = 2'd2;
        end else if (low == CH_DEL) begin
            low_b[0] = CH_CARET;
            low_b[1] = CH_QMARK;
            low_len  = 2'd2;
        end else begin
            low_b[0] = low;
            low_b[1] = low;
            low_len  = 2'd1;
        end

        for (int k = 0; k < BODY_MAX; k++) begin
            body[k] = i_in_byte;
        end
        body_len = 3'd1;
        if (is_nl) begin
            if (r_cfg.show_ends) begin
                body[0]  = CH_DOLLAR;
                body[1]  = CH_NL;
                body_len = 3'd2;
            end
        end else if (i_in_byte == CH_TAB) begin
            if (r_cfg.show_tabs) begin
                body[0]  = CH_CARET;
                body[1]  = CH_I;
                body_len = 3'd2;
            end
        end else if (r_cfg.show_nonprint) begin
            if (i_in_byte[7]) begin
                body[0]  = CH_M;
                body[1]  = CH_DASH;
                body[2]  = low_b[0];
                body[3]  = low_b[1];
                body_len = 3'd2 + {1'b0, low_len};
            end else begin
                body[0]  = low_b[0];
                body[1]  = low_b[1];
                body_len = {1'b0, low_len};
            end
        end
    end

    // assemble the full run: number columns and tab, then the body
    always_comb begin
        hi_zero[NUMBER_DIGITS] = 1'b1;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            hi_zero[i] = hi_zero[i+1] && (r_line[4*i +: 4] == 4'd0);
        end
        for (int k = 0; k < RUN_MAX; k++) begin
            n_run[k] = CH_SPACE;
            if (numbered) begin
                if (k < NUMBER_DIGITS) begin
                    if (!(hi_zero[NUMBER_DIGITS-1-k] && (NUMBER_DIGITS - 1 - k) != 0)) begin
                        n_run[k] = CH_ZERO
                                   + {4'd0, r_line[4*(NUMBER_DIGITS-1-k) +: 4]};
                    end
                end else if (k == NUMBER_DIGITS) begin
                    n_run[k] = CH_TAB;
                end else begin
                    n_run[k] = body[2'(k - NUMBER_DIGITS - 1)];
                end
            end else if (k < BODY_MAX) begin
                n_run[k] = body[2'(k)];
            end
        end
        n_len  = (numbered ? CNT_W'(NUMBER_DIGITS + 1) : CNT_W'(0)) + CNT_W'(body_len);
        n_load = in_take && !drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= '0;
            r_after_nl <= 1'b1;
            r_blank    <= 2'd0;
            r_line     <= LINE_W'(1);
            r_cnt      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NUMBER_ALL:      r_cfg.number_all      <= i_cfg_data;
                    CFG_NUMBER_NONBLANK: r_cfg.number_nonblank <= i_cfg_data;
                    CFG_SQUEEZE_BLANK:   r_cfg.squeeze_blank   <= i_cfg_data;
                    CFG_SHOW_ENDS:       r_cfg.show_ends       <= i_cfg_data;
                    CFG_SHOW_TABS:       r_cfg.show_tabs       <= i_cfg_data;
                    CFG_SHOW_NONPRINT:   r_cfg.show_nonprint   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_take) begin
                r_after_nl <= n_after_nl;
                r_blank    <= n_blank;
                if (numbered && !drop) begin
                    r_line <= n_line;
                end
            end
            if (n_load) begin
                r_cnt <= n_len;
            end else if (out_take) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // run buffer: load a whole run, shift one byte out per take
    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_run <= n_run;
        end else if (out_take) begin
            for (int k = 0; k < RUN_MAX - 1; k++) begin
                r_run[k] <= r_run[k+1];
            end
        end
    end

    `ASSERT_SAME(a_take_only_at_drain, i_clk, i_rst_n,
        in_take && (r_cnt != '0), o_run_last && !i_out_stall)
    `ASSERT_SAME(a_cnt_in_range, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(RUN_MAX))
    `ASSERT_SAME(a_low_digit_bcd, i_clk, i_rst_n, 1'b1, r_line[3:0] <= 4'd9)
    `ASSERT_NEXT(a_empty_after_last, i_clk, i_rst_n,
        out_take && o_run_last && !in_take, !o_out_valid)

endmodule

`default_nettype wire
